### src/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg - shared types and constants of the balance cascade controller
// Microcode word, datapath selects, register map and fixed widths.
// ----------------------------------------------------------------------------
package bcc_pkg;

    // field widths
    localparam int PITCH_W  = 13;
    localparam int COUNT_W  = 16;
    localparam int GAIN_W   = 24;
    localparam int LIMIT_W  = 16;
    localparam int DRIVE_W  = 17;
    localparam int PDIFF_W  = 14;
    localparam int ERR_W    = 17;
    localparam int FE_W     = 18;
    localparam int INTEG_W  = 17;
    localparam int MUL_A_W  = 24;
    localparam int MUL_B_W  = 18;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int ACC_W    = 46;
    localparam int TERM_W   = 34;
    localparam int SUM_W    = TERM_W + 1;

    // configuration register map
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_MECH_ZERO   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BALANCE_KP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BALANCE_KD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_KP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_KI    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT = 3'd6;

    localparam logic signed [PITCH_W-1:0] RST_MECH_ZERO   = -13'sd136;
    localparam logic signed [GAIN_W-1:0]  RST_BALANCE_KP  = -24'sd88320;
    localparam logic signed [GAIN_W-1:0]  RST_BALANCE_KD  = -24'sd256;
    localparam logic signed [GAIN_W-1:0]  RST_SPEED_KP    = 24'sd28160;
    localparam logic signed [GAIN_W-1:0]  RST_SPEED_KI    = 24'sd141;
    localparam logic [LIMIT_W-1:0]        RST_INTEG_LIMIT = 16'd10000;
    localparam logic [LIMIT_W-1:0]        RST_DRIVE_LIMIT = 16'd7000;

    // low-pass weights, /256
    localparam logic signed [MUL_A_W-1:0] K_NEW = 24'sd77;
    localparam logic signed [MUL_A_W-1:0] K_OLD = 24'sd179;

    // microcode
    typedef enum logic [2:0] {
        A_BKP, A_BKD, A_SKP, A_SKI, A_KNEW, A_KOLD
    } t_a_sel;

    typedef enum logic [2:0] {
        B_PDIFF, B_RATE, B_ERR, B_FE, B_INTEG
    } t_b_sel;

    typedef enum logic [1:0] {
        ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_ADD_SH4
    } t_acc_op;

    typedef enum logic [2:0] {
        WR_NONE, WR_BAL, WR_FE, WR_INTEG, WR_SPD, WR_DRIVE, WR_OFF
    } t_wr_op;

    typedef enum logic [1:0] {
        SEQ_NEXT, SEQ_END, SEQ_JMP_OFF
    } t_seq_op;

    localparam int PROG_LEN = 12;
    localparam int STEP_W   = 4;

    typedef struct packed {
        t_a_sel            a_sel;
        t_b_sel            b_sel;
        logic              mul_en;
        t_acc_op           acc_op;
        t_wr_op            wr_op;
        t_seq_op           seq_op;
        logic [STEP_W-1:0] target;
    } t_uword;

    localparam t_uword UW_NOP = '{A_BKP, B_PDIFF, 1'b0, ACC_HOLD, WR_NONE, SEQ_NEXT, 4'd0};

    localparam t_uword PROGRAM [PROG_LEN] = '{
        '{A_BKP,  B_PDIFF, 1'b1, ACC_HOLD,    WR_NONE,  SEQ_NEXT,    4'd0},
        '{A_BKD,  B_RATE,  1'b1, ACC_LOAD,    WR_NONE,  SEQ_NEXT,    4'd0},
        '{A_KNEW, B_ERR,   1'b1, ACC_ADD_SH4, WR_NONE,  SEQ_NEXT,    4'd0},
        '{A_KOLD, B_FE,    1'b1, ACC_LOAD,    WR_BAL,   SEQ_NEXT,    4'd0},
        '{A_BKP,  B_PDIFF, 1'b0, ACC_ADD,     WR_NONE,  SEQ_NEXT,    4'd0},
        '{A_BKP,  B_PDIFF, 1'b0, ACC_HOLD,    WR_FE,    SEQ_NEXT,    4'd0},
        '{A_SKP,  B_ERR,   1'b1, ACC_HOLD,    WR_INTEG, SEQ_NEXT,    4'd0},
        '{A_SKI,  B_INTEG, 1'b1, ACC_LOAD,    WR_NONE,  SEQ_NEXT,    4'd0},
        '{A_BKP,  B_PDIFF, 1'b0, ACC_ADD,     WR_NONE,  SEQ_NEXT,    4'd0},
        '{A_BKP,  B_PDIFF, 1'b0, ACC_HOLD,    WR_SPD,   SEQ_NEXT,    4'd0},
        '{A_BKP,  B_PDIFF, 1'b0, ACC_HOLD,    WR_DRIVE, SEQ_JMP_OFF, 4'd11},
        '{A_BKP,  B_PDIFF, 1'b0, ACC_HOLD,    WR_OFF,   SEQ_END,     4'd0}
    };

    // datapath status back to the sequencer
    typedef struct packed {
        logic                        off;
        logic signed [DRIVE_W-1:0]   drive;
    } t_dp_stat;

endpackage

### src/bcc_in_if.sv
// ----------------------------------------------------------------------------
// bcc_in_if - sensor tick channel
// valid/ready channel carrying one control tick of sensor data.
// ----------------------------------------------------------------------------
interface bcc_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [bcc_pkg::PITCH_W-1:0]   pitch_angle;
    logic signed [bcc_pkg::COUNT_W-1:0]   gyro_pitch_rate;
    logic signed [bcc_pkg::COUNT_W-1:0]   left_count;
    logic signed [bcc_pkg::COUNT_W-1:0]   right_count;
    logic                                 shutdown;

    modport source (
        output valid, pitch_angle, gyro_pitch_rate, left_count, right_count, shutdown,
        input  ready
    );
    modport sink (
        input  valid, pitch_angle, gyro_pitch_rate, left_count, right_count, shutdown,
        output ready
    );
endinterface

### src/bcc_out_if.sv
// ----------------------------------------------------------------------------
// bcc_out_if - motor command channel
// valid/ready channel carrying one motor drive result per tick.
// ----------------------------------------------------------------------------
interface bcc_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [bcc_pkg::DRIVE_W-1:0]   motor_drive;
    logic                                 drive_enable;

    modport source (output valid, motor_drive, drive_enable, input ready);
    modport sink   (input  valid, motor_drive, drive_enable, output ready);
endinterface

### src/bcc_datapath.sv
// ----------------------------------------------------------------------------
// bcc_datapath - shared multiply-accumulate datapath
// One registered multiplier, an accumulator and the loop state, steered by
// the microcode word of the current step.
// ----------------------------------------------------------------------------
module bcc_datapath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  bcc_pkg::t_uword                        i_uw,
    input  logic                                   i_load,
    input  logic signed [bcc_pkg::PITCH_W-1:0]     i_pitch_angle,
    input  logic signed [bcc_pkg::COUNT_W-1:0]     i_gyro_pitch_rate,
    input  logic signed [bcc_pkg::COUNT_W-1:0]     i_left_count,
    input  logic signed [bcc_pkg::COUNT_W-1:0]     i_right_count,
    input  logic                                   i_shutdown,
    input  logic signed [bcc_pkg::PITCH_W-1:0]     i_mech_zero,
    input  logic signed [bcc_pkg::GAIN_W-1:0]      i_balance_kp,
    input  logic signed [bcc_pkg::GAIN_W-1:0]      i_balance_kd,
    input  logic signed [bcc_pkg::GAIN_W-1:0]      i_speed_kp,
    input  logic signed [bcc_pkg::GAIN_W-1:0]      i_speed_ki,
    input  logic        [bcc_pkg::LIMIT_W-1:0]     i_integ_limit,
    input  logic        [bcc_pkg::LIMIT_W-1:0]     i_drive_limit,
    output bcc_pkg::t_dp_stat                      o_stat
);

    localparam int IW = bcc_pkg::INTEG_W + 2;

    // tick operands
    logic signed [bcc_pkg::PDIFF_W-1:0]  r_pdiff;
    logic signed [bcc_pkg::COUNT_W-1:0]  r_rate;
    logic signed [bcc_pkg::ERR_W-1:0]    r_err;
    logic                                r_off;

    // loop state and intermediates
    logic signed [bcc_pkg::FE_W-1:0]     r_fe;
    logic signed [bcc_pkg::INTEG_W-1:0]  r_integ;
    logic signed [bcc_pkg::PROD_W-1:0]   r_prod;
    logic signed [bcc_pkg::ACC_W-1:0]    r_acc;
    logic signed [bcc_pkg::TERM_W-1:0]   r_bal;
    logic signed [bcc_pkg::TERM_W-1:0]   r_spd;

    logic signed [bcc_pkg::MUL_A_W-1:0]  mul_a;
    logic signed [bcc_pkg::MUL_B_W-1:0]  mul_b;
    logic signed [bcc_pkg::ACC_W-1:0]    prod_ext;
    logic signed [bcc_pkg::ACC_W-1:0]    acc_b12;
    logic signed [bcc_pkg::ACC_W-1:0]    acc_b8;
    logic signed [IW-1:0]                integ_sum;
    logic signed [IW-1:0]                integ_lim;
    logic signed [bcc_pkg::INTEG_W-1:0]  n_integ;
    logic signed [bcc_pkg::SUM_W-1:0]    drive_sum;
    logic signed [bcc_pkg::SUM_W-1:0]    drive_lim;
    logic signed [bcc_pkg::DRIVE_W-1:0]  drive_clamped;

    always_comb begin
        case (i_uw.a_sel)
            bcc_pkg::A_BKP:  mul_a = i_balance_kp;
            bcc_pkg::A_BKD:  mul_a = i_balance_kd;
            bcc_pkg::A_SKP:  mul_a = i_speed_kp;
            bcc_pkg::A_SKI:  mul_a = i_speed_ki;
            bcc_pkg::A_KNEW: mul_a = bcc_pkg::K_NEW;
            bcc_pkg::A_KOLD: mul_a = bcc_pkg::K_OLD;
            default:         mul_a = '0;
        endcase
        case (i_uw.b_sel)
            bcc_pkg::B_PDIFF: mul_b = bcc_pkg::MUL_B_W'(r_pdiff);
            bcc_pkg::B_RATE:  mul_b = bcc_pkg::MUL_B_W'(r_rate);
            bcc_pkg::B_ERR:   mul_b = bcc_pkg::MUL_B_W'(r_err);
            bcc_pkg::B_FE:    mul_b = bcc_pkg::MUL_B_W'(r_fe);
            bcc_pkg::B_INTEG: mul_b = bcc_pkg::MUL_B_W'(r_integ);
            default:          mul_b = '0;
        endcase
    end

    // truncation toward zero: bias negatives before the arithmetic shift
    assign prod_ext = bcc_pkg::ACC_W'(r_prod);
    assign acc_b12  = r_acc + (r_acc[bcc_pkg::ACC_W-1] ? 46'sd4095 : 46'sd0);
    assign acc_b8   = r_acc + (r_acc[bcc_pkg::ACC_W-1] ? 46'sd255 : 46'sd0);

    always_comb begin
        integ_sum = IW'(r_integ) + IW'(r_fe);
        integ_lim = signed'({3'b000, i_integ_limit});
        if (integ_sum > integ_lim) begin
            n_integ = bcc_pkg::INTEG_W'(integ_lim);
        end else if (integ_sum < -integ_lim) begin
            n_integ = bcc_pkg::INTEG_W'(-integ_lim);
        end else begin
            n_integ = bcc_pkg::INTEG_W'(integ_sum);
        end
    end

    always_comb begin
        drive_sum = bcc_pkg::SUM_W'(r_bal) + bcc_pkg::SUM_W'(r_spd);
        drive_lim = signed'({{(bcc_pkg::SUM_W-bcc_pkg::LIMIT_W){1'b0}}, i_drive_limit});
        if (drive_sum > drive_lim) begin
            drive_clamped = bcc_pkg::DRIVE_W'(drive_lim);
        end else if (drive_sum < -drive_lim) begin
            drive_clamped = bcc_pkg::DRIVE_W'(-drive_lim);
        end else begin
            drive_clamped = bcc_pkg::DRIVE_W'(drive_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pdiff <= bcc_pkg::PDIFF_W'(i_pitch_angle) - bcc_pkg::PDIFF_W'(i_mech_zero);
            r_rate  <= i_gyro_pitch_rate;
            r_err   <= bcc_pkg::ERR_W'(i_left_count) - bcc_pkg::ERR_W'(i_right_count);
            r_off   <= i_shutdown;
        end
        if (i_uw.mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        case (i_uw.acc_op)
            bcc_pkg::ACC_LOAD:    r_acc <= prod_ext;
            bcc_pkg::ACC_ADD:     r_acc <= r_acc + prod_ext;
            bcc_pkg::ACC_ADD_SH4: r_acc <= r_acc + (prod_ext <<< 4);
            default:              r_acc <= r_acc;
        endcase
        if (i_uw.wr_op == bcc_pkg::WR_BAL) begin
            r_bal <= bcc_pkg::TERM_W'(acc_b12 >>> 12);
        end
        if (i_uw.wr_op == bcc_pkg::WR_SPD) begin
            r_spd <= bcc_pkg::TERM_W'(acc_b8 >>> 8);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fe    <= '0;
            r_integ <= '0;
        end else begin
            case (i_uw.wr_op)
                bcc_pkg::WR_FE:    r_fe    <= bcc_pkg::FE_W'(acc_b8 >>> 8);
                bcc_pkg::WR_INTEG: r_integ <= n_integ;
                bcc_pkg::WR_OFF:   r_integ <= '0;
                default: begin
                end
            endcase
        end
    end

    assign o_stat.off   = r_off;
    assign o_stat.drive = drive_clamped;

endmodule

### src/balance_cascade_controller.sv
// ----------------------------------------------------------------------------
// balance_cascade_controller - two-wheel balance PD / speed PI cascade
// Microcoded sequencer over a shared multiply-accumulate datapath.
// ----------------------------------------------------------------------------
// One tick is taken per beat on i_in when the sequencer is free. The tick is
// latched as it is taken, then a 12-entry microcode program runs on a single
// registered 24x18 multiplier: 11 steps per tick, 12 when shutdown is set
// (an extra step clears the speed integral). No new tick is accepted before
// the program has run to its end. The result sits in an output register, so
// the next tick can start while it waits; the sequencer only stalls at the
// drive step if the previous result has still not been taken. Registers
// are written through i_cfg_* and must only change while no tick is pending.
module balance_cascade_controller (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    bcc_in_if.sink                                i_in,
    bcc_out_if.source                             o_out,
    input  logic                                  i_cfg_wr_en,
    input  logic [bcc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [bcc_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    logic signed [bcc_pkg::PITCH_W-1:0]  r_mech_zero;
    logic signed [bcc_pkg::GAIN_W-1:0]   r_balance_kp;
    logic signed [bcc_pkg::GAIN_W-1:0]   r_balance_kd;
    logic signed [bcc_pkg::GAIN_W-1:0]   r_speed_kp;
    logic signed [bcc_pkg::GAIN_W-1:0]   r_speed_ki;
    logic        [bcc_pkg::LIMIT_W-1:0]  r_integ_limit;
    logic        [bcc_pkg::LIMIT_W-1:0]  r_drive_limit;

    logic                                r_busy;
    logic [bcc_pkg::STEP_W-1:0]          r_step;
    logic                                n_busy;
    logic [bcc_pkg::STEP_W-1:0]          n_step;
    logic                                r_out_valid;
    logic signed [bcc_pkg::DRIVE_W-1:0]  r_out_drive;
    logic                                r_out_enable;

    bcc_pkg::t_uword                     uw_cur;
    bcc_pkg::t_uword                     uw_exec;
    bcc_pkg::t_dp_stat                   dp_stat;
    logic                                in_beat;
    logic                                out_beat;
    logic                                stall;
    logic                                advance;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mech_zero   <= bcc_pkg::RST_MECH_ZERO;
            r_balance_kp  <= bcc_pkg::RST_BALANCE_KP;
            r_balance_kd  <= bcc_pkg::RST_BALANCE_KD;
            r_speed_kp    <= bcc_pkg::RST_SPEED_KP;
            r_speed_ki    <= bcc_pkg::RST_SPEED_KI;
            r_integ_limit <= bcc_pkg::RST_INTEG_LIMIT;
            r_drive_limit <= bcc_pkg::RST_DRIVE_LIMIT;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                bcc_pkg::REG_MECH_ZERO:   r_mech_zero   <= i_cfg_data[bcc_pkg::PITCH_W-1:0];
                bcc_pkg::REG_BALANCE_KP:  r_balance_kp  <= i_cfg_data;
                bcc_pkg::REG_BALANCE_KD:  r_balance_kd  <= i_cfg_data;
                bcc_pkg::REG_SPEED_KP:    r_speed_kp    <= i_cfg_data;
                bcc_pkg::REG_SPEED_KI:    r_speed_ki    <= i_cfg_data;
                bcc_pkg::REG_INTEG_LIMIT: r_integ_limit <= i_cfg_data[bcc_pkg::LIMIT_W-1:0];
                bcc_pkg::REG_DRIVE_LIMIT: r_drive_limit <= i_cfg_data[bcc_pkg::LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer
    assign i_in.ready = !r_busy;
    assign in_beat    = i_in.valid && !r_busy;
    assign out_beat   = r_out_valid && o_out.ready;

    assign uw_cur  = bcc_pkg::PROGRAM[r_step];
    // drive step waits for a free output register
    assign stall   = (uw_cur.wr_op == bcc_pkg::WR_DRIVE) && r_out_valid && !o_out.ready;
    assign advance = r_busy && !stall;
    assign uw_exec = advance ? uw_cur : bcc_pkg::UW_NOP;

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        if (in_beat) begin
            n_busy = 1'b1;
            n_step = '0;
        end else if (advance) begin
            case (uw_cur.seq_op)
                bcc_pkg::SEQ_NEXT: n_step = r_step + 1'b1;
                bcc_pkg::SEQ_END:  n_busy = 1'b0;
                bcc_pkg::SEQ_JMP_OFF: begin
                    if (dp_stat.off) begin
                        n_step = uw_cur.target;
                    end else begin
                        n_busy = 1'b0;
                    end
                end
                default: n_busy = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
            if (uw_exec.wr_op == bcc_pkg::WR_DRIVE) begin
                r_out_valid <= 1'b1;
            end else if (out_beat) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (uw_exec.wr_op == bcc_pkg::WR_DRIVE) begin
            r_out_drive  <= dp_stat.off ? '0 : dp_stat.drive;
            r_out_enable <= !dp_stat.off;
        end
    end

    bcc_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_uw              (uw_exec),
        .i_load            (in_beat),
        .i_pitch_angle     (i_in.pitch_angle),
        .i_gyro_pitch_rate (i_in.gyro_pitch_rate),
        .i_left_count      (i_in.left_count),
        .i_right_count     (i_in.right_count),
        .i_shutdown        (i_in.shutdown),
        .i_mech_zero       (r_mech_zero),
        .i_balance_kp      (r_balance_kp),
        .i_balance_kd      (r_balance_kd),
        .i_speed_kp        (r_speed_kp),
        .i_speed_ki        (r_speed_ki),
        .i_integ_limit     (r_integ_limit),
        .i_drive_limit     (r_drive_limit),
        .o_stat            (dp_stat)
    );

    assign o_out.valid        = r_out_valid;
    assign o_out.motor_drive  = r_out_drive;
    assign o_out.drive_enable = r_out_enable;

    // checks
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> (r_busy && r_step == '0))
        else $error("tick beat did not start the program");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_step < bcc_pkg::STEP_W'(bcc_pkg::PROG_LEN)))
        else $error("step counter left the program");

    a_valid_from_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(uw_exec.wr_op == bcc_pkg::WR_DRIVE))
        else $error("result raised outside the drive step");

    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_enable) |-> (r_out_drive == '0))
        else $error("drive nonzero while disabled");

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench - balance cascade controller
// Drives sensor ticks through the valid/ready input channel and checks every
// motor command against a cycle-free model of the PD balance and PI speed
// loops. A directed table covers reset state, clamps, shutdown and register
// corner cases; random phases follow under several gain and limit settings
// with random idling on both channels in all but the last two phases.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 30;
    localparam int PHASE_TICKS    = 132;
    localparam int MAX_REPORTS    = 10;
    localparam int DIR_ROWS       = 25;

    // index past the register map, writes must be dropped
    localparam logic [bcc_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    typedef enum logic { ROW_TICK, ROW_CFG } t_row_kind;
    typedef enum logic { BY_MODEL, FIXED } t_check;
    typedef enum logic [2:0] {
        PH_DEFAULT, PH_RANDOM, PH_MAX, PH_MIN, PH_TUNED, PH_MIXED
    } t_phase;

    typedef struct packed {
        logic signed [bcc_pkg::PITCH_W-1:0] pitch;
        logic signed [bcc_pkg::COUNT_W-1:0] rate;
        logic signed [bcc_pkg::COUNT_W-1:0] left;
        logic signed [bcc_pkg::COUNT_W-1:0] right;
        logic                               shutdown;
    } t_sensor_tick;

    typedef struct packed {
        logic signed [bcc_pkg::DRIVE_W-1:0] drive;
        logic                               enable;
    } t_motor_cmd;

    typedef struct packed {
        t_row_kind                          kind;
        t_check                             check;
        logic [bcc_pkg::CFG_IDX_W-1:0]      idx;
        logic [bcc_pkg::CFG_DATA_W-1:0]     data;
        logic signed [bcc_pkg::PITCH_W-1:0] pitch;
        logic signed [bcc_pkg::COUNT_W-1:0] rate;
        logic signed [bcc_pkg::COUNT_W-1:0] left;
        logic signed [bcc_pkg::COUNT_W-1:0] right;
        logic                               shutdown;
        logic signed [bcc_pkg::DRIVE_W-1:0] exp_drive;
        logic                               exp_enable;
    } t_dir_row;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_wr_en;
    logic [bcc_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [bcc_pkg::CFG_DATA_W-1:0] i_cfg_data;

    bcc_in_if  in_ch ();
    bcc_out_if out_ch ();

    balance_cascade_controller u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // model copy of the register file
    logic signed [bcc_pkg::PITCH_W-1:0] mech_zero = bcc_pkg::RST_MECH_ZERO;
    logic signed [bcc_pkg::GAIN_W-1:0]  bal_kp    = bcc_pkg::RST_BALANCE_KP;
    logic signed [bcc_pkg::GAIN_W-1:0]  bal_kd    = bcc_pkg::RST_BALANCE_KD;
    logic signed [bcc_pkg::GAIN_W-1:0]  spd_kp    = bcc_pkg::RST_SPEED_KP;
    logic signed [bcc_pkg::GAIN_W-1:0]  spd_ki    = bcc_pkg::RST_SPEED_KI;
    logic [bcc_pkg::LIMIT_W-1:0]        integ_lim = bcc_pkg::RST_INTEG_LIMIT;
    logic [bcc_pkg::LIMIT_W-1:0]        drive_lim = bcc_pkg::RST_DRIVE_LIMIT;

    // loop state
    longint filt_err    = 0;
    longint speed_integ = 0;

    t_motor_cmd pending_cmds [$];
    int         mismatches   = 0;
    int         quiet_cycles = 0;
    int         src_idle     = 0;
    int         snk_idle     = 0;
    bit         cfg_open     = 0;

    t_dir_row directed_rows [DIR_ROWS] = '{
        // reset state, pitch on the balance point: nothing to drive
        '{ROW_TICK, FIXED,    3'd0, 24'd0, -13'sd136, 16'sd0, 16'sd0, 16'sd0, 1'b0,
          17'sd0, 1'b1},
        // full tilt with full rate, clamped both ways
        '{ROW_TICK, FIXED,    3'd0, 24'd0, 13'sd2880, 16'sd32767, 16'sd0, 16'sd0, 1'b0,
          -17'sd7000, 1'b1},
        '{ROW_TICK, FIXED,    3'd0, 24'd0, -13'sd2880, -16'sd32768, 16'sd0, 16'sd0, 1'b0,
          17'sd7000, 1'b1},
        '{ROW_TICK, BY_MODEL, 3'd0, 24'd0, 13'sd0, 16'sd0, 16'sd32767, -16'sd32768, 1'b0,
          17'sd0, 1'b0},
        '{ROW_TICK, FIXED,    3'd0, 24'd0, 13'sd0, 16'sd0, 16'sd32767, -16'sd32768, 1'b1,
          17'sd0, 1'b0},
        // pitch patterns beyond the physical range
        '{ROW_TICK, BY_MODEL, 3'd0, 24'd0, -13'sd4096, 16'sd12345, -16'sd32768, 16'sd32767,
          1'b0, 17'sd0, 1'b0},
        '{ROW_TICK, BY_MODEL, 3'd0, 24'd0, 13'sd4095, -16'sd1, 16'sd100, -16'sd100, 1'b0,
          17'sd0, 1'b0},
        '{ROW_TICK, FIXED,    3'd0, 24'd0, 13'sd1, 16'sd0, 16'sd0, 16'sd0, 1'b1,
          17'sd0, 1'b0},
        '{ROW_CFG,  BY_MODEL, REG_UNMAPPED, 24'hFFFFFF, 13'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0,
          17'sd0, 1'b0},
        '{ROW_CFG,  BY_MODEL, bcc_pkg::REG_DRIVE_LIMIT, 24'h000000, 13'sd0, 16'sd0, 16'sd0,
          16'sd0, 1'b0, 17'sd0, 1'b0},
        '{ROW_TICK, FIXED,    3'd0, 24'd0, 13'sd2880, 16'sd32767, 16'sd5, -16'sd5, 1'b0,
          17'sd0, 1'b1},
        // widest gains and limits: products at their largest
        '{ROW_CFG,  BY_MODEL, bcc_pkg::REG_BALANCE_KP, 24'h7FFFFF, 13'sd0, 16'sd0, 16'sd0,
          16'sd0, 1'b0, 17'sd0, 1'b0},
        '{ROW_CFG,  BY_MODEL, bcc_pkg::REG_BALANCE_KD, 24'h800000, 13'sd0, 16'sd0, 16'sd0,
          16'sd0, 1'b0, 17'sd0, 1'b0},
        '{ROW_CFG,  BY_MODEL, bcc_pkg::REG_SPEED_KP, 24'h7FFFFF, 13'sd0, 16'sd0, 16'sd0,
          16'sd0, 1'b0, 17'sd0, 1'b0},
        '{ROW_CFG,  BY_MODEL, bcc_pkg::REG_SPEED_KI, 24'h800000, 13'sd0, 16'sd0, 16'sd0,
          16'sd0, 1'b0, 17'sd0, 1'b0},
        '{ROW_CFG,  BY_MODEL, bcc_pkg::REG_INTEG_LIMIT, 24'h00FFFF, 13'sd0, 16'sd0, 16'sd0,
          16'sd0, 1'b0, 17'sd0, 1'b0},
        '{ROW_CFG,  BY_MODEL, bcc_pkg::REG_DRIVE_LIMIT, 24'h00FFFF, 13'sd0, 16'sd0, 16'sd0,
          16'sd0, 1'b0, 17'sd0, 1'b0},
        // upper data bits must be dropped: zero point lands on -4096
        '{ROW_CFG,  BY_MODEL, bcc_pkg::REG_MECH_ZERO, 24'hFFF000, 13'sd0, 16'sd0, 16'sd0,
          16'sd0, 1'b0, 17'sd0, 1'b0},
        '{ROW_TICK, BY_MODEL, 3'd0, 24'd0, 13'sd4095, -16'sd32768, 16'sd32767, -16'sd32768,
          1'b0, 17'sd0, 1'b0},
        '{ROW_TICK, BY_MODEL, 3'd0, 24'd0, -13'sd4096, 16'sd32767, 16'sd32767, -16'sd32768,
          1'b0, 17'sd0, 1'b0},
        '{ROW_TICK, BY_MODEL, 3'd0, 24'd0, 13'sd0, 16'sd0, 16'sd32767, -16'sd32768, 1'b0,
          17'sd0, 1'b0},
        // integral bound dropped below the accumulated value
        '{ROW_CFG,  BY_MODEL, bcc_pkg::REG_INTEG_LIMIT, 24'h000003, 13'sd0, 16'sd0, 16'sd0,
          16'sd0, 1'b0, 17'sd0, 1'b0},
        '{ROW_TICK, BY_MODEL, 3'd0, 24'd0, 13'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0,
          17'sd0, 1'b0},
        '{ROW_TICK, FIXED,    3'd0, 24'd0, 13'sd0, 16'sd0, -16'sd32768, 16'sd32767, 1'b1,
          17'sd0, 1'b0},
        '{ROW_TICK, BY_MODEL, 3'd0, 24'd0, 13'sd0, 16'sd0, 16'sd1, 16'sd0, 1'b0,
          17'sd0, 1'b0}
    };

    function automatic longint saturate(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic void update_reg(logic [bcc_pkg::CFG_IDX_W-1:0] idx,
                                       logic [bcc_pkg::CFG_DATA_W-1:0] d);
        case (idx)
            bcc_pkg::REG_MECH_ZERO:   mech_zero = d[bcc_pkg::PITCH_W-1:0];
            bcc_pkg::REG_BALANCE_KP:  bal_kp    = d;
            bcc_pkg::REG_BALANCE_KD:  bal_kd    = d;
            bcc_pkg::REG_SPEED_KP:    spd_kp    = d;
            bcc_pkg::REG_SPEED_KI:    spd_ki    = d;
            bcc_pkg::REG_INTEG_LIMIT: integ_lim = d[bcc_pkg::LIMIT_W-1:0];
            bcc_pkg::REG_DRIVE_LIMIT: drive_lim = d[bcc_pkg::LIMIT_W-1:0];
            default: ;
        endcase
    endfunction

    // one control tick of the cascade; advances the filter and the integral
    function automatic t_motor_cmd predict_motor_cmd(t_sensor_tick t);
        t_motor_cmd cmd;
        longint     balance;
        longint     err;
        longint     speed;
        longint     drive;
        balance = (longint'(bal_kp) * (longint'(t.pitch) - longint'(mech_zero))
                   + 16 * longint'(bal_kd) * longint'(t.rate)) / 4096;
        err = longint'(t.left) - longint'(t.right);
        filt_err = (77 * err + 179 * filt_err) / 256;
        speed_integ = saturate(speed_integ + filt_err, longint'(integ_lim));
        speed = (longint'(spd_kp) * err + longint'(spd_ki) * speed_integ) / 256;
        drive = saturate(balance + speed, longint'(drive_lim));
        if (t.shutdown) begin
            speed_integ = 0;
            cmd.drive  = '0;
            cmd.enable = 1'b0;
        end else begin
            cmd.drive  = drive[bcc_pkg::DRIVE_W-1:0];
            cmd.enable = 1'b1;
        end
        return cmd;
    endfunction

    function automatic logic signed [bcc_pkg::COUNT_W-1:0] pick_count(int span, int wide_pct);
        int v;
        if ($urandom_range(0, 99) < wide_pct) begin
            v = $urandom;
        end else begin
            v = int'($urandom_range(0, 2 * span)) - span;
        end
        return v[bcc_pkg::COUNT_W-1:0];
    endfunction

    function automatic logic signed [bcc_pkg::PITCH_W-1:0] pick_pitch(int wide_pct);
        int v;
        if ($urandom_range(0, 99) < wide_pct) begin
            v = $urandom;
        end else begin
            v = int'($urandom_range(0, 5760)) - 2880;
        end
        return v[bcc_pkg::PITCH_W-1:0];
    endfunction

    function automatic logic [bcc_pkg::CFG_DATA_W-1:0] reg_setting(
        t_phase ph, logic [bcc_pkg::CFG_IDX_W-1:0] idx);
        logic [bcc_pkg::CFG_DATA_W-1:0] rst_val [7];
        int                             g;
        rst_val[bcc_pkg::REG_MECH_ZERO]   = bcc_pkg::CFG_DATA_W'(bcc_pkg::RST_MECH_ZERO);
        rst_val[bcc_pkg::REG_BALANCE_KP]  = bcc_pkg::RST_BALANCE_KP;
        rst_val[bcc_pkg::REG_BALANCE_KD]  = bcc_pkg::RST_BALANCE_KD;
        rst_val[bcc_pkg::REG_SPEED_KP]    = bcc_pkg::RST_SPEED_KP;
        rst_val[bcc_pkg::REG_SPEED_KI]    = bcc_pkg::RST_SPEED_KI;
        rst_val[bcc_pkg::REG_INTEG_LIMIT] = bcc_pkg::CFG_DATA_W'(bcc_pkg::RST_INTEG_LIMIT);
        rst_val[bcc_pkg::REG_DRIVE_LIMIT] = bcc_pkg::CFG_DATA_W'(bcc_pkg::RST_DRIVE_LIMIT);
        case (ph)
            PH_DEFAULT: return rst_val[idx];
            PH_RANDOM:  return bcc_pkg::CFG_DATA_W'($urandom);
            PH_MAX: begin
                if (idx == bcc_pkg::REG_MECH_ZERO) return 24'd2880;
                if (idx == bcc_pkg::REG_INTEG_LIMIT || idx == bcc_pkg::REG_DRIVE_LIMIT)
                    return 24'h00FFFF;
                return 24'h7FFFFF;
            end
            PH_MIN: begin
                if (idx == bcc_pkg::REG_MECH_ZERO) return -24'sd2880;
                if (idx == bcc_pkg::REG_INTEG_LIMIT) return 24'd0;
                if (idx == bcc_pkg::REG_DRIVE_LIMIT) return 24'd1;
                return 24'h800000;
            end
            PH_TUNED: begin
                if (idx == bcc_pkg::REG_MECH_ZERO)
                    return bcc_pkg::CFG_DATA_W'(pick_pitch(0));
                if (idx == bcc_pkg::REG_INTEG_LIMIT || idx == bcc_pkg::REG_DRIVE_LIMIT)
                    return bcc_pkg::CFG_DATA_W'($urandom_range(0, 20000));
                g = int'($urandom_range(0, 131072)) - 65536 + int'($signed(rst_val[idx]));
                return g[bcc_pkg::CFG_DATA_W-1:0];
            end
            default: begin
                if (idx == bcc_pkg::REG_MECH_ZERO)
                    return bcc_pkg::CFG_DATA_W'(pick_pitch(0));
                if (idx == bcc_pkg::REG_INTEG_LIMIT || idx == bcc_pkg::REG_DRIVE_LIMIT)
                    return bcc_pkg::CFG_DATA_W'($urandom_range(0, 65535));
                return bcc_pkg::CFG_DATA_W'($urandom);
            end
        endcase
    endfunction

    // stop sending and wait for every command to come back
    task automatic drain_ticks();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [bcc_pkg::CFG_IDX_W-1:0] idx,
                             logic [bcc_pkg::CFG_DATA_W-1:0] d);
        if (!cfg_open) drain_ticks();
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        update_reg(idx, d);
        cfg_open = 1'b1;
    endtask

    task automatic send_tick(t_sensor_tick t, t_check chk, t_motor_cmd fixed_cmd);
        t_motor_cmd cmd;
        if (cfg_open) begin
            @(negedge i_clk);
            i_cfg_wr_en <= 1'b0;
            cfg_open = 1'b0;
        end
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.pitch_angle     <= t.pitch;
        in_ch.gyro_pitch_rate <= t.rate;
        in_ch.left_count      <= t.left;
        in_ch.right_count     <= t.right;
        in_ch.shutdown        <= t.shutdown;
        do @(posedge i_clk); while (!in_ch.ready);
        cmd = predict_motor_cmd(t);
        pending_cmds.push_back(chk == FIXED ? fixed_cmd : cmd);
    endtask

    task automatic note_mismatch(string field, longint want, longint got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch on %s: expected %0d, got %0d", field, want, got);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // command sink with random backpressure
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= ($urandom_range(0, 99) >= snk_idle);
        end
    end

    always @(posedge i_clk) begin : check_cmd
        t_motor_cmd want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_cmds.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected command beat: drive %0d enable %0b",
                             out_ch.motor_drive, out_ch.drive_enable);
            end else begin
                want = pending_cmds.pop_front();
                if (out_ch.motor_drive !== want.drive)
                    note_mismatch("motor_drive", longint'(want.drive),
                                  longint'(out_ch.motor_drive));
                if (out_ch.drive_enable !== want.enable)
                    note_mismatch("drive_enable", longint'(want.enable),
                                  longint'(out_ch.drive_enable));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        t_sensor_tick t;
        t_motor_cmd   fixed_cmd;
        t_phase       ph;
        in_ch.valid           = 1'b0;
        in_ch.pitch_angle     = '0;
        in_ch.gyro_pitch_rate = '0;
        in_ch.left_count      = '0;
        in_ch.right_count     = '0;
        in_ch.shutdown        = 1'b0;
        i_cfg_wr_en           = 1'b0;
        i_cfg_index           = '0;
        i_cfg_data            = '0;
        i_rst_n               = 1'b0;
        src_idle              = 27;
        snk_idle              = 75;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                cfg_write(directed_rows[i].idx, directed_rows[i].data);
            end else begin
                t.pitch          = directed_rows[i].pitch;
                t.rate           = directed_rows[i].rate;
                t.left           = directed_rows[i].left;
                t.right          = directed_rows[i].right;
                t.shutdown       = directed_rows[i].shutdown;
                fixed_cmd.drive  = directed_rows[i].exp_drive;
                fixed_cmd.enable = directed_rows[i].exp_enable;
                send_tick(t, directed_rows[i].check, fixed_cmd);
            end
        end

        fixed_cmd = '0;
        for (int p = 0; p < 6; p++) begin
            ph = t_phase'(p);
            for (int r = 0; r < 7; r++)
                cfg_write(bcc_pkg::CFG_IDX_W'(r), reg_setting(ph, bcc_pkg::CFG_IDX_W'(r)));
            // occasional dropped write past the map
            if ($urandom_range(0, 1) == 0)
                cfg_write(REG_UNMAPPED, bcc_pkg::CFG_DATA_W'($urandom));
            case (p / 2)
                0:       begin src_idle = 27; snk_idle = 75; end
                1:       begin src_idle = 75; snk_idle = 27; end
                default: begin src_idle = 0;  snk_idle = 0;  end
            endcase
            for (int n = 0; n < PHASE_TICKS; n++) begin
                t.pitch    = pick_pitch(12);
                t.rate     = pick_count(600, 50);
                t.left     = pick_count(300, 25);
                t.right    = pick_count(300, 25);
                t.shutdown = ($urandom_range(0, 9) == 0);
                send_tick(t, BY_MODEL, fixed_cmd);
            end
        end

        drain_ticks();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_cmds.size() != 0) begin
            $display("%0d commands never arrived", pending_cmds.size());
            mismatches += pending_cmds.size();
        end
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
